// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is held.
`define ASSERT_SYNC(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked check that also runs during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== hdl/lse_pkg.sv =====
package lse_pkg;

    localparam int LINE_PIXELS = 128;
    localparam int IDX_W       = $clog2(LINE_PIXELS);
    localparam int POS_W       = IDX_W + 1;
    localparam int PIX_W       = 10;
    localparam int DIFF_W      = PIX_W + 1;
    localparam int SCAN_FIRST  = 3;
    localparam int CENTRE_REF  = 64;
    localparam int CTR_W       = 7;
    localparam int GAIN_W      = 4;
    localparam int BND_W       = 7;
    localparam int SC_W        = 12;
    localparam int SL_W        = 11;
    localparam int SERVO_W     = 13;
    localparam int SUM_W       = 14;
    localparam int CMP_W       = ((IDX_W > BND_W) ? IDX_W : BND_W) + 2;
    localparam int PROD_W      = CMP_W + GAIN_W + 1;
    // c / 5 == (c * DIV5_MUL) >> DIV5_SH, one step low at worst
    localparam int DIV5_MUL    = 13107;
    localparam int DIV5_SH     = 16;
    localparam int DIV5_W      = IDX_W + DIV5_SH;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;
    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 24;

    typedef enum logic [1:0] {
        STEER_PROP  = 2'd0,
        STEER_LEFT  = 2'd1,
        STEER_RIGHT = 2'd2
    } steer_kind_t;

    typedef enum logic [2:0] {
        REG_STEER_GAIN   = 3'd0,
        REG_LEFT_BOUND   = 3'd1,
        REG_RIGHT_BOUND  = 3'd2,
        REG_MIN_WIDTH    = 3'd3,
        REG_MAX_WIDTH    = 3'd4,
        REG_JUMP_LIMIT   = 3'd5,
        REG_SERVO_CENTRE = 3'd6,
        REG_SERVO_LIMIT  = 3'd7
    } reg_addr_t;

    typedef struct packed {
        logic [GAIN_W-1:0] steer_gain;
        logic [BND_W-1:0]  left_bound;
        logic [BND_W-1:0]  right_bound;
        logic [BND_W-1:0]  min_width;
        logic [BND_W-1:0]  max_width;
        logic [BND_W-1:0]  jump_limit;
        logic [SC_W-1:0]   servo_centre;
        logic [SL_W-1:0]   servo_limit;
    } lse_cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0] rise_idx;
        logic [IDX_W-1:0] fall_idx;
    } lse_edges_t;

    typedef struct packed {
        steer_kind_t      kind;
        logic [IDX_W-1:0] centre;
        logic [CTR_W-1:0] shown;
    } lse_cmd_t;

endpackage

// ===== hdl/lse_scan.sv =====
module lse_scan (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [lse_pkg::PIX_W-1:0]         pixel,
    input  logic                              line_start,
    output logic                              ev_valid,
    input  logic                              ev_ready,
    output lse_pkg::lse_edges_t               ev
);

    logic [lse_pkg::PIX_W-1:0]         prev_pix_reg, prev_pix_next;
    logic [lse_pkg::POS_W-1:0]         pos_reg, pos_next;
    logic signed [lse_pkg::DIFF_W-1:0] best_rise_reg, best_rise_next;
    logic signed [lse_pkg::DIFF_W-1:0] best_fall_reg, best_fall_next;
    logic [lse_pkg::IDX_W-1:0]         rise_idx_reg, rise_idx_next;
    logic [lse_pkg::IDX_W-1:0]         fall_idx_reg, fall_idx_next;
    logic                              ev_valid_reg, ev_valid_next;
    lse_pkg::lse_edges_t               ev_reg, ev_next;

    logic                              accept;
    logic                              line_done;
    logic [lse_pkg::POS_W-1:0]         pos_eff;
    logic [lse_pkg::POS_W-1:0]         pos_dec;
    logic [lse_pkg::IDX_W-1:0]         idx;
    logic signed [lse_pkg::DIFF_W-1:0] diff;

    assign s_ready  = !ev_valid_reg || ev_ready;
    assign accept   = s_valid && s_ready;
    assign ev_valid = ev_valid_reg;
    assign ev       = ev_reg;

    assign pos_eff = line_start ? '0 : pos_reg;
    assign pos_dec = pos_eff - lse_pkg::POS_W'(1);
    assign idx     = pos_dec[lse_pkg::IDX_W-1:0];
    assign diff    = $signed({1'b0, pixel}) - $signed({1'b0, prev_pix_reg});

    always_comb begin
        prev_pix_next  = prev_pix_reg;
        pos_next       = pos_reg;
        best_rise_next = best_rise_reg;
        best_fall_next = best_fall_reg;
        rise_idx_next  = rise_idx_reg;
        fall_idx_next  = fall_idx_reg;
        line_done      = 1'b0;
        if (accept && (pos_eff < lse_pkg::POS_W'(lse_pkg::LINE_PIXELS))) begin
            prev_pix_next = pixel;
            if (pos_eff != '0) begin
                if (idx == lse_pkg::IDX_W'(lse_pkg::SCAN_FIRST)) begin
                    best_rise_next = diff;
                    best_fall_next = diff;
                    rise_idx_next  = idx;
                    fall_idx_next  = idx;
                end else if (idx > lse_pkg::IDX_W'(lse_pkg::SCAN_FIRST)) begin
                    if (diff > best_rise_reg) begin
                        best_rise_next = diff;
                        rise_idx_next  = idx;
                    end
                    if (diff < best_fall_reg) begin
                        best_fall_next = diff;
                        fall_idx_next  = idx;
                    end
                end
            end
            if (pos_eff == lse_pkg::POS_W'(lse_pkg::LINE_PIXELS - 1)) begin
                line_done = 1'b1;
                pos_next  = lse_pkg::POS_W'(lse_pkg::LINE_PIXELS);
            end else begin
                pos_next = pos_eff + lse_pkg::POS_W'(1);
            end
        end
        ev_valid_next = (ev_valid_reg && !ev_ready) || line_done;
        ev_next       = ev_reg;
        if (line_done) begin
            ev_next.rise_idx = rise_idx_next;
            ev_next.fall_idx = fall_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_pix_reg  <= '0;
            pos_reg       <= '0;
            best_rise_reg <= '0;
            best_fall_reg <= '0;
            rise_idx_reg  <= lse_pkg::IDX_W'(lse_pkg::SCAN_FIRST);
            fall_idx_reg  <= lse_pkg::IDX_W'(lse_pkg::SCAN_FIRST);
            ev_valid_reg  <= 1'b0;
        end else begin
            prev_pix_reg  <= prev_pix_next;
            pos_reg       <= pos_next;
            best_rise_reg <= best_rise_next;
            best_fall_reg <= best_fall_next;
            rise_idx_reg  <= rise_idx_next;
            fall_idx_reg  <= fall_idx_next;
            ev_valid_reg  <= ev_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ev_reg <= ev_next;
    end

endmodule

// ===== hdl/lse_centre.sv =====
module lse_centre (
    input  logic                aclk,
    input  logic                aresetn,
    input  lse_pkg::lse_cfg_t   cfg,
    input  logic                ev_valid,
    output logic                ev_ready,
    input  lse_pkg::lse_edges_t ev,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output lse_pkg::lse_cmd_t   cmd
);

    logic [lse_pkg::CTR_W-1:0]        prev_centre_reg, prev_centre_next;
    logic [lse_pkg::CTR_W-1:0]        line_centre_reg, line_centre_next;
    logic                             cmd_valid_reg, cmd_valid_next;
    lse_pkg::lse_cmd_t                cmd_reg, cmd_next;

    logic                             take;
    logic                             in_window;
    logic                             hard_left;
    logic                             hard_right;
    logic                             jump;
    logic signed [lse_pkg::CMP_W-1:0] width;
    logic [lse_pkg::IDX_W:0]          idx_sum;
    logic [lse_pkg::IDX_W-1:0]        centre;
    logic [lse_pkg::DIV5_W-1:0]       div_prod;
    logic [lse_pkg::IDX_W-1:0]        q0;
    logic [lse_pkg::IDX_W-1:0]        rem;
    logic [lse_pkg::IDX_W-1:0]        fifth;
    logic [lse_pkg::IDX_W-1:0]        damped;

    assign ev_ready  = !cmd_valid_reg || cmd_ready;
    assign take      = ev_valid && ev_ready;
    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

    assign width = $signed(lse_pkg::CMP_W'(ev.rise_idx))
                 - $signed(lse_pkg::CMP_W'(ev.fall_idx));
    assign in_window = (width > $signed(lse_pkg::CMP_W'(cfg.min_width)))
                    && (width < $signed(lse_pkg::CMP_W'(cfg.max_width)));
    assign hard_left  = lse_pkg::CMP_W'(ev.fall_idx) < lse_pkg::CMP_W'(cfg.left_bound);
    assign hard_right = lse_pkg::CMP_W'(ev.rise_idx) > lse_pkg::CMP_W'(cfg.right_bound);

    assign idx_sum = {1'b0, ev.rise_idx} + {1'b0, ev.fall_idx};
    assign centre  = idx_sum[lse_pkg::IDX_W:1];
    assign jump    = ($signed(lse_pkg::CMP_W'(centre))
                    - $signed(lse_pkg::CMP_W'(prev_centre_reg)))
                   > $signed(lse_pkg::CMP_W'(cfg.jump_limit));

    // divide by five: reciprocal multiply, then one correction step
    assign div_prod = lse_pkg::DIV5_W'(centre) * lse_pkg::DIV5_W'(lse_pkg::DIV5_MUL);
    assign q0       = div_prod[lse_pkg::DIV5_W-1:lse_pkg::DIV5_SH];
    assign rem      = centre - (q0 << 2) - q0;
    assign fifth    = (rem >= lse_pkg::IDX_W'(5)) ? q0 + lse_pkg::IDX_W'(1) : q0;
    assign damped   = jump ? fifth : centre;

    always_comb begin
        prev_centre_next = prev_centre_reg;
        line_centre_next = line_centre_reg;
        cmd_next         = cmd_reg;
        cmd_valid_next   = (cmd_valid_reg && !cmd_ready) || (take && in_window);
        if (take && in_window) begin
            cmd_next.centre = damped;
            if (hard_left) begin
                cmd_next.kind  = lse_pkg::STEER_LEFT;
                cmd_next.shown = line_centre_reg;
            end else if (hard_right) begin
                cmd_next.kind  = lse_pkg::STEER_RIGHT;
                cmd_next.shown = line_centre_reg;
            end else begin
                cmd_next.kind    = lse_pkg::STEER_PROP;
                cmd_next.shown   = lse_pkg::CTR_W'(damped);
                prev_centre_next = lse_pkg::CTR_W'(centre);
                line_centre_next = lse_pkg::CTR_W'(damped);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_centre_reg <= lse_pkg::CTR_W'(lse_pkg::CENTRE_REF);
            line_centre_reg <= lse_pkg::CTR_W'(lse_pkg::CENTRE_REF);
            cmd_valid_reg   <= 1'b0;
        end else begin
            prev_centre_reg <= prev_centre_next;
            line_centre_reg <= line_centre_next;
            cmd_valid_reg   <= cmd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
    end

endmodule

// ===== hdl/lse_servo.sv =====
module lse_servo (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lse_pkg::lse_cfg_t           cfg,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  lse_pkg::lse_cmd_t           cmd,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [lse_pkg::SERVO_W-1:0] servo_value,
    output lse_pkg::steer_kind_t        steer_kind,
    output logic [lse_pkg::CTR_W-1:0]   line_centre
);

    logic                              m_valid_reg, m_valid_next;
    logic [lse_pkg::SERVO_W-1:0]       servo_reg, servo_next;
    lse_pkg::steer_kind_t              kind_reg, kind_next;
    logic [lse_pkg::CTR_W-1:0]         centre_reg, centre_next;

    logic                              take;
    logic signed [lse_pkg::CMP_W-1:0]  offset;
    logic signed [lse_pkg::PROD_W-1:0] corr;
    logic signed [lse_pkg::PROD_W-1:0] lim;
    logic signed [lse_pkg::PROD_W-1:0] clamped;
    logic signed [lse_pkg::SUM_W-1:0]  base;
    logic signed [lse_pkg::SUM_W-1:0]  lim_s;
    logic signed [lse_pkg::SUM_W-1:0]  total;

    assign cmd_ready   = !m_valid_reg || m_ready;
    assign take        = cmd_valid && cmd_ready;
    assign m_valid     = m_valid_reg;
    assign servo_value = servo_reg;
    assign steer_kind  = kind_reg;
    assign line_centre = centre_reg;

    assign offset = $signed(lse_pkg::CMP_W'(cmd.centre))
                  - $signed(lse_pkg::CMP_W'(lse_pkg::CENTRE_REF));
    assign corr   = $signed(lse_pkg::PROD_W'(cfg.steer_gain)) * lse_pkg::PROD_W'(offset);
    assign lim    = $signed(lse_pkg::PROD_W'(cfg.servo_limit));
    assign base   = $signed(lse_pkg::SUM_W'(cfg.servo_centre));
    assign lim_s  = $signed(lse_pkg::SUM_W'(cfg.servo_limit));

    always_comb begin
        if (corr > lim) begin
            clamped = lim;
        end else if (corr < -lim) begin
            clamped = -lim;
        end else begin
            clamped = corr;
        end
        case (cmd.kind)
            lse_pkg::STEER_LEFT:  total = base - lim_s;
            lse_pkg::STEER_RIGHT: total = base + lim_s;
            default:              total = base + lse_pkg::SUM_W'(clamped);
        endcase
    end

    always_comb begin
        m_valid_next = (m_valid_reg && !m_ready) || take;
        servo_next   = servo_reg;
        kind_next    = kind_reg;
        centre_next  = centre_reg;
        if (take) begin
            servo_next  = (total < 0) ? '0 : total[lse_pkg::SERVO_W-1:0];
            kind_next   = cmd.kind;
            centre_next = cmd.shown;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        servo_reg  <= servo_next;
        kind_reg   <= kind_next;
        centre_reg <= centre_next;
    end

endmodule

// ===== hdl/line_scan_edge_steering.sv =====
// Line-scan edge steering. Takes 128 pixels to a line (a line_start flag
// restarts the line), and keeps the first largest and smallest neighbour
// difference over difference indices 3 to 126. On the last pixel the
// edge width (rise index minus fall index) is checked against
// min_width/max_width; inside the window one item comes out: a hard
// left/right steer at servo_centre -/+ servo_limit, or a proportional steer
// around the edge midpoint, divided by five when it rises by more than
// jump_limit. Outside the window nothing comes out. Sustained rate is one
// pixel per clock unless stalled; the pipeline is scan, centre and servo
// stages, each behind its own register. Registers sit on the APB port at
// byte offset 4*index and should only be written while the block is idle.
module line_scan_edge_steering (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lse_pkg::TDATA_IN_W-1:0]    s_tdata,  // pixel[9:0], zero pad
    input  logic                              s_tuser,  // line_start
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lse_pkg::TDATA_OUT_W-1:0]   m_tdata,  // servo_value[12:0], line_centre[19:13]
    output logic [1:0]                        m_tuser,  // steer_kind[1:0]
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lse_pkg::ADDR_W-1:0]        paddr,
    input  logic [lse_pkg::DATA_W-1:0]        pwdata,
    output logic [lse_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);

    lse_pkg::lse_cfg_t           cfg_reg, cfg_next;
    lse_pkg::reg_addr_t          reg_sel;
    logic                        cfg_write;

    logic                        ev_valid;
    logic                        ev_ready;
    lse_pkg::lse_edges_t         ev;
    logic                        cmd_valid;
    logic                        cmd_ready;
    lse_pkg::lse_cmd_t           cmd;
    logic [lse_pkg::SERVO_W-1:0] servo_value;
    lse_pkg::steer_kind_t        steer_kind;
    logic [lse_pkg::CTR_W-1:0]   line_centre;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = lse_pkg::reg_addr_t'(paddr[lse_pkg::ADDR_W-1:2]);

    always_comb begin
        cfg_next = cfg_reg;
        prdata   = '0;
        unique case (reg_sel)
            lse_pkg::REG_STEER_GAIN: begin
                prdata = lse_pkg::DATA_W'(cfg_reg.steer_gain);
                if (cfg_write) cfg_next.steer_gain = pwdata[lse_pkg::GAIN_W-1:0];
            end
            lse_pkg::REG_LEFT_BOUND: begin
                prdata = lse_pkg::DATA_W'(cfg_reg.left_bound);
                if (cfg_write) cfg_next.left_bound = pwdata[lse_pkg::BND_W-1:0];
            end
            lse_pkg::REG_RIGHT_BOUND: begin
                prdata = lse_pkg::DATA_W'(cfg_reg.right_bound);
                if (cfg_write) cfg_next.right_bound = pwdata[lse_pkg::BND_W-1:0];
            end
            lse_pkg::REG_MIN_WIDTH: begin
                prdata = lse_pkg::DATA_W'(cfg_reg.min_width);
                if (cfg_write) cfg_next.min_width = pwdata[lse_pkg::BND_W-1:0];
            end
            lse_pkg::REG_MAX_WIDTH: begin
                prdata = lse_pkg::DATA_W'(cfg_reg.max_width);
                if (cfg_write) cfg_next.max_width = pwdata[lse_pkg::BND_W-1:0];
            end
            lse_pkg::REG_JUMP_LIMIT: begin
                prdata = lse_pkg::DATA_W'(cfg_reg.jump_limit);
                if (cfg_write) cfg_next.jump_limit = pwdata[lse_pkg::BND_W-1:0];
            end
            lse_pkg::REG_SERVO_CENTRE: begin
                prdata = lse_pkg::DATA_W'(cfg_reg.servo_centre);
                if (cfg_write) cfg_next.servo_centre = pwdata[lse_pkg::SC_W-1:0];
            end
            lse_pkg::REG_SERVO_LIMIT: begin
                prdata = lse_pkg::DATA_W'(cfg_reg.servo_limit);
                if (cfg_write) cfg_next.servo_limit = pwdata[lse_pkg::SL_W-1:0];
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.steer_gain   <= lse_pkg::GAIN_W'(3);
            cfg_reg.left_bound   <= lse_pkg::BND_W'(40);
            cfg_reg.right_bound  <= lse_pkg::BND_W'(90);
            cfg_reg.min_width    <= lse_pkg::BND_W'(10);
            cfg_reg.max_width    <= lse_pkg::BND_W'(30);
            cfg_reg.jump_limit   <= lse_pkg::BND_W'(50);
            cfg_reg.servo_centre <= lse_pkg::SC_W'(1600);
            cfg_reg.servo_limit  <= lse_pkg::SL_W'(300);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    lse_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .pixel      (s_tdata[lse_pkg::PIX_W-1:0]),
        .line_start (s_tuser),
        .ev_valid   (ev_valid),
        .ev_ready   (ev_ready),
        .ev         (ev)
    );

    lse_centre u_centre (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .ev_valid  (ev_valid),
        .ev_ready  (ev_ready),
        .ev        (ev),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    lse_servo u_servo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .servo_value (servo_value),
        .steer_kind  (steer_kind),
        .line_centre (line_centre)
    );

    assign m_tdata = {4'b0000, line_centre, servo_value};
    assign m_tuser = steer_kind;

endmodule

// ===== hdl/lse_checker.sv =====
`include "assert_macros.svh"

module lse_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [lse_pkg::TDATA_IN_W-1:0]  s_tdata,
    input logic                            s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [lse_pkg::TDATA_OUT_W-1:0] m_tdata,
    input logic [1:0]                      m_tuser,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [lse_pkg::ADDR_W-1:0]      paddr,
    input logic [lse_pkg::DATA_W-1:0]      pwdata,
    input logic [lse_pkg::DATA_W-1:0]      prdata,
    input logic                            pready
);

    `ASSERT_SYNC(a_out_idle_after_reset, aclk, aresetn, $past(!aresetn) |-> !m_tvalid)

    `ASSERT_SYNC(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    `ASSERT_SYNC(a_cfg_readback, aclk, aresetn, psel && penable && pwrite && pready && (paddr[lse_pkg::ADDR_W-1:2] == lse_pkg::REG_SERVO_CENTRE) |=> (paddr[lse_pkg::ADDR_W-1:2] != lse_pkg::REG_SERVO_CENTRE) || (prdata[lse_pkg::SC_W-1:0] == $past(pwdata[lse_pkg::SC_W-1:0])))

    `ASSERT_ALWAYS(a_pready_high, aclk, pready)

endmodule

bind line_scan_edge_steering lse_checker u_lse_checker (.*);

// ===== tb/tb.sv =====
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lse_pkg::*;

    localparam int SETTLE_CYCLES    = 8;
    localparam int DRAIN_LIMIT      = 4000;
    localparam int CYCLE_LIMIT      = 6_000_000;
    localparam int RANDOM_ITEMS     = 1750;
    localparam int MIN_RESULTS      = 48;
    localparam int MAX_RANDOM_LINES = 150;

    typedef struct packed {
        logic [SERVO_W-1:0] servo;
        steer_kind_t        kind;
        logic [CTR_W-1:0]   centre;
    } steer_out_t;

    typedef enum logic {ROW_LINE, ROW_CFG} row_op_t;
    typedef enum {SHAPE_EDGES, SHAPE_NOISE, SHAPE_STEPS} shape_t;

    typedef struct packed {
        row_op_t     op;
        reg_addr_t   addr;
        logic [31:0] value;
        logic [7:0]  fall_at;
        logic [7:0]  rise_at;
        logic [9:0]  level;
        logic [9:0]  depth;
        logic        start;
        logic [7:0]  restart;
        logic [7:0]  trail;
        logic        typed;
        logic        silent;
        steer_out_t  want;
    } scan_row_t;

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    wire                     s_tready;
    logic [TDATA_IN_W-1:0]   s_tdata  = '0;  // pixel[9:0], zero pad
    logic                    s_tuser  = 1'b0; // line_start
    wire                     m_tvalid;
    logic                    m_tready = 1'b0;
    wire  [TDATA_OUT_W-1:0]  m_tdata;  // servo_value[12:0], line_centre[19:13]
    wire  [1:0]              m_tuser;  // steer_kind[1:0]
    logic                    psel     = 1'b0;
    logic                    penable  = 1'b0;
    logic                    pwrite   = 1'b0;
    logic [ADDR_W-1:0]       paddr    = '0;
    logic [DATA_W-1:0]       pwdata   = '0;
    wire  [DATA_W-1:0]       prdata;
    wire                     pready;

    line_scan_edge_steering dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 aclk = ~aclk;

    // edge tracker state
    lse_cfg_t         cfg_now;
    logic [PIX_W-1:0] last_pix    = '0;
    int               scan_pos    = 0;
    int               top_rise    = 0;
    int               low_fall    = 0;
    int               rise_pos    = SCAN_FIRST;
    int               fall_pos    = SCAN_FIRST;
    logic [CTR_W-1:0] centre_now  = CTR_W'(CENTRE_REF);
    logic [CTR_W-1:0] centre_prev = CTR_W'(CENTRE_REF);

    steer_out_t steer_q [$];
    scan_row_t  plan [$];

    int errors         = 0;
    int pixels_used    = 0;
    int lines_sent     = 0;
    int reg_writes     = 0;
    int results_queued = 0;
    int seen_prop      = 0;
    int seen_left      = 0;
    int seen_right     = 0;
    int cycle_count    = 0;
    bit tx_calm        = 1'b0;
    int rx_hold        = 0;
    bit rx_level       = 1'b1;

    function automatic void flag_error(string msg);
        errors++;
        if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function automatic bit judge_line(output steer_out_t res);
        int          w;
        int          c;
        int          corr;
        int          lim;
        int          servo;
        steer_kind_t kind;
        w   = rise_pos - fall_pos;
        res = '0;
        if (!(w > int'(cfg_now.min_width) && w < int'(cfg_now.max_width))) return 1'b0;
        lim = int'(cfg_now.servo_limit);
        if (fall_pos < int'(cfg_now.left_bound)) begin
            servo = int'(cfg_now.servo_centre) - lim;
            kind  = STEER_LEFT;
        end else if (rise_pos > int'(cfg_now.right_bound)) begin
            servo = int'(cfg_now.servo_centre) + lim;
            kind  = STEER_RIGHT;
        end else begin
            c = (rise_pos + fall_pos) / 2;
            if (c - int'(centre_prev) > int'(cfg_now.jump_limit)) begin
                centre_prev = CTR_W'(c);
                c = c / 5;
            end else begin
                centre_prev = CTR_W'(c);
            end
            centre_now = CTR_W'(c);
            corr = int'(cfg_now.steer_gain) * (c - CENTRE_REF);
            if (corr > lim) corr = lim;
            else if (corr < -lim) corr = -lim;
            servo = int'(cfg_now.servo_centre) + corr;
            kind  = STEER_PROP;
        end
        if (servo < 0) servo = 0;
        res.servo  = SERVO_W'(servo);
        res.kind   = kind;
        res.centre = centre_now;
        return 1'b1;
    endfunction

    function automatic bit track_pixel(input logic [PIX_W-1:0] pix, input bit start,
                                       output steer_out_t res);
        int d;
        int idx;
        res = '0;
        if (start) scan_pos = 0;
        if (scan_pos >= LINE_PIXELS) return 1'b0;
        pixels_used++;
        if (scan_pos >= 1) begin
            d   = int'(pix) - int'(last_pix);
            idx = scan_pos - 1;
            if (idx == SCAN_FIRST) begin
                top_rise = d;
                low_fall = d;
                rise_pos = idx;
                fall_pos = idx;
            end else if (idx > SCAN_FIRST) begin
                if (d > top_rise) begin top_rise = d; rise_pos = idx; end
                if (d < low_fall) begin low_fall = d; fall_pos = idx; end
            end
        end
        last_pix = pix;
        if (scan_pos == LINE_PIXELS - 1) begin
            scan_pos = LINE_PIXELS;
            return judge_line(res);
        end
        scan_pos++;
        return 1'b0;
    endfunction

    function automatic scan_row_t line_row(int f, int r, int level, int depth, bit start,
                                           int restart, int trail);
        scan_row_t row;
        row         = '0;
        row.op      = ROW_LINE;
        row.fall_at = 8'(f);
        row.rise_at = 8'(r);
        row.level   = 10'(level);
        row.depth   = 10'(depth);
        row.start   = start;
        row.restart = 8'(restart);
        row.trail   = 8'(trail);
        return row;
    endfunction

    function automatic scan_row_t typed_steer(scan_row_t row, int servo, steer_kind_t kind,
                                              int centre);
        row.typed       = 1'b1;
        row.want.servo  = SERVO_W'(servo);
        row.want.kind   = kind;
        row.want.centre = CTR_W'(centre);
        return row;
    endfunction

    function automatic scan_row_t typed_silent(scan_row_t row);
        row.typed  = 1'b1;
        row.silent = 1'b1;
        return row;
    endfunction

    function automatic scan_row_t cfg_row(reg_addr_t addr, int value);
        scan_row_t row;
        row       = '0;
        row.op    = ROW_CFG;
        row.addr  = addr;
        row.value = 32'(value);
        return row;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (tx_calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 0;
        if (roll < 97) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_reg(int lo, int hi);
        int roll;
        roll = $urandom_range(0, 7);
        if (roll == 0) return lo;
        if (roll == 1) return hi;
        return $urandom_range(lo, hi);
    endfunction

    task automatic push_pixel(input logic [PIX_W-1:0] pix, input bit start, input bit hold);
        int         gap;
        bit         got;
        steer_out_t res;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_IN_W'(pix);
        s_tuser  <= start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        got = track_pixel(pix, start, res);
        if (got && !hold) begin
            steer_q.push_back(res);
            results_queued++;
        end
    endtask

    task automatic send_line(input shape_t shape, input int f, input int r, input int level,
                             input int depth, input int noise, input bit start,
                             input int restart, input int trail, input bit typed,
                             input bit silent, input steer_out_t want);
        int k;
        int v;
        int lo;
        tx_calm = ($urandom_range(0, 3) == 0);
        lo = level - depth;
        for (k = 0; k < restart; k++)
            push_pixel(PIX_W'($urandom_range(0, 1023)), k == 0, 1'b0);
        for (k = 0; k < LINE_PIXELS; k++) begin
            case (shape)
                SHAPE_NOISE: v = $urandom_range(0, 1023);
                SHAPE_STEPS: v = $urandom_range(0, 3) * 341;
                default: begin
                    if (f < r) v = (k > f && k <= r) ? lo : level;
                    else       v = (k > r && k <= f) ? level : lo;
                    if (noise > 0) v = v + int'($urandom_range(0, 2 * noise)) - noise;
                    if (v < 0) v = 0;
                    if (v > 1023) v = 1023;
                end
            endcase
            push_pixel(PIX_W'(v), start && k == 0, typed && k == LINE_PIXELS - 1);
        end
        if (typed && !silent) begin
            steer_q.push_back(want);
            results_queued++;
        end
        for (k = 0; k < trail; k++)
            push_pixel(PIX_W'($urandom_range(0, 1023)), 1'b0, 1'b0);
        lines_sent++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (steer_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_addr_t addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({addr, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        case (addr)
            REG_STEER_GAIN:   cfg_now.steer_gain   = value[GAIN_W-1:0];
            REG_LEFT_BOUND:   cfg_now.left_bound   = value[BND_W-1:0];
            REG_RIGHT_BOUND:  cfg_now.right_bound  = value[BND_W-1:0];
            REG_MIN_WIDTH:    cfg_now.min_width    = value[BND_W-1:0];
            REG_MAX_WIDTH:    cfg_now.max_width    = value[BND_W-1:0];
            REG_JUMP_LIMIT:   cfg_now.jump_limit   = value[BND_W-1:0];
            REG_SERVO_CENTRE: cfg_now.servo_centre = value[SC_W-1:0];
            REG_SERVO_LIMIT:  cfg_now.servo_limit  = value[SL_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    always @(posedge aclk) begin : result_check
        steer_out_t want;
        int         roll;
        if (aresetn && m_tvalid && m_tready) begin
            if (steer_q.size() == 0) begin
                flag_error($sformatf("unexpected item servo=%0d kind=%0d centre=%0d",
                                     m_tdata[12:0], m_tuser, m_tdata[19:13]));
            end else begin
                want = steer_q.pop_front();
                if (m_tdata[12:0] !== want.servo || m_tuser !== want.kind ||
                    m_tdata[19:13] !== want.centre)
                    flag_error($sformatf("servo %0d/%0d kind %0d/%0d centre %0d/%0d (exp/got)",
                                         want.servo, m_tdata[12:0], want.kind, m_tuser,
                                         want.centre, m_tdata[19:13]));
                case (want.kind)
                    STEER_LEFT:  seen_left++;
                    STEER_RIGHT: seen_right++;
                    default:     seen_prop++;
                endcase
            end
        end
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= rx_level;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
                rx_level = 1'b0;
                rx_hold  = $urandom_range(10, 40);
                m_tready <= 1'b0;
            end else if (roll < 4) begin
                rx_level = 1'b1;
                rx_hold  = $urandom_range(100, 300);
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, steer_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int     base_items;
        int     base_results;
        int     rand_lines;
        int     burst;
        int     j;
        int     f;
        int     r;
        int     w;
        int     level;
        int     depth;
        int     noise;
        int     min_w;
        int     wait_cycles;
        shape_t shape;

        cfg_now = '{steer_gain: 4'd3, left_bound: 7'd40, right_bound: 7'd90,
                    min_width: 7'd10, max_width: 7'd30, jump_limit: 7'd50,
                    servo_centre: 12'd1600, servo_limit: 11'd300};

        // reset defaults; first line goes in without line_start
        plan.push_back(typed_steer(line_row(50, 70, 800, 400, 0, 0, 0), 1588, STEER_PROP, 60));
        plan.push_back(typed_steer(line_row(30, 45, 600, 300, 1, 0, 0), 1300, STEER_LEFT, 60));
        plan.push_back(typed_steer(line_row(80, 100, 900, 500, 1, 0, 0), 1900, STEER_RIGHT, 60));
        plan.push_back(typed_silent(line_row(50, 55, 700, 350, 1, 0, 0)));
        plan.push_back(typed_silent(line_row(50, 60, 700, 350, 1, 0, 0)));
        plan.push_back(typed_silent(line_row(50, 80, 700, 350, 1, 0, 0)));
        plan.push_back(typed_silent(line_row(70, 50, 700, 350, 1, 0, 0)));
        plan.push_back(typed_silent(line_row(20, 20, 512, 0, 1, 0, 0)));
        plan.push_back(line_row(55, 75, 700, 350, 1, 60, 0));
        plan.push_back(line_row(52, 70, 700, 350, 1, 0, 20));
        plan.push_back(line_row(50, 72, 1023, 1023, 1, 0, 0));
        plan.push_back(line_row(1, 20, 500, 250, 1, 0, 0));
        plan.push_back(line_row(100, 126, 500, 250, 1, 0, 0));
        plan.push_back(cfg_row(REG_STEER_GAIN, 15));
        plan.push_back(cfg_row(REG_LEFT_BOUND, 0));
        plan.push_back(cfg_row(REG_RIGHT_BOUND, 127));
        plan.push_back(cfg_row(REG_MIN_WIDTH, 0));
        plan.push_back(cfg_row(REG_MAX_WIDTH, 127));
        plan.push_back(cfg_row(REG_JUMP_LIMIT, 0));
        plan.push_back(cfg_row(REG_SERVO_CENTRE, 4095));
        plan.push_back(cfg_row(REG_SERVO_LIMIT, 2047));
        plan.push_back(line_row(3, 126, 900, 450, 1, 0, 0));
        plan.push_back(line_row(100, 110, 900, 450, 1, 0, 0));
        plan.push_back(cfg_row(REG_JUMP_LIMIT, 127));
        plan.push_back(line_row(10, 20, 900, 450, 1, 0, 0));
        plan.push_back(cfg_row(REG_SERVO_LIMIT, 0));
        plan.push_back(line_row(40, 60, 900, 450, 1, 0, 0));
        plan.push_back(cfg_row(REG_RIGHT_BOUND, 0));
        plan.push_back(line_row(40, 60, 900, 450, 1, 0, 0));
        plan.push_back(cfg_row(REG_SERVO_LIMIT, 2047));
        plan.push_back(cfg_row(REG_LEFT_BOUND, 127));
        plan.push_back(line_row(40, 60, 900, 450, 1, 0, 0));
        plan.push_back(cfg_row(REG_SERVO_CENTRE, 0));
        plan.push_back(line_row(40, 60, 900, 450, 1, 0, 0));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].op == ROW_CFG) begin
                settle();
                write_reg(plan[i].addr, plan[i].value);
            end else begin
                send_line(SHAPE_EDGES, plan[i].fall_at, plan[i].rise_at, plan[i].level,
                          plan[i].depth, 0, plan[i].start, plan[i].restart, plan[i].trail,
                          plan[i].typed, plan[i].silent, plan[i].want);
            end
        end

        base_items   = pixels_used;
        base_results = results_queued;
        rand_lines   = 0;
        while ((pixels_used - base_items < RANDOM_ITEMS ||
                results_queued - base_results < MIN_RESULTS) &&
               rand_lines < MAX_RANDOM_LINES) begin
            // new register setting only once the block has gone quiet
            settle();
            min_w = ($urandom_range(0, 9) == 0) ? pick_reg(0, 127) : $urandom_range(0, 20);
            write_reg(REG_STEER_GAIN, pick_reg(0, 15));
            write_reg(REG_LEFT_BOUND, ($urandom_range(0, 4) == 0) ? pick_reg(0, 127)
                                                                   : $urandom_range(0, 50));
            write_reg(REG_RIGHT_BOUND, ($urandom_range(0, 4) == 0) ? pick_reg(0, 127)
                                                                    : $urandom_range(70, 127));
            write_reg(REG_MIN_WIDTH, min_w);
            write_reg(REG_MAX_WIDTH, ($urandom_range(0, 9) == 0) ? pick_reg(0, 127)
                                                                  : min_w + $urandom_range(2, 40));
            write_reg(REG_JUMP_LIMIT, pick_reg(0, 127));
            write_reg(REG_SERVO_CENTRE, pick_reg(0, 4095));
            write_reg(REG_SERVO_LIMIT, pick_reg(0, 2047));
            burst = $urandom_range(4, 10);
            for (j = 0; j < burst; j++) begin
                case ($urandom_range(0, 15))
                    0:       shape = SHAPE_NOISE;
                    1:       shape = SHAPE_STEPS;
                    default: shape = SHAPE_EDGES;
                endcase
                f = $urandom_range(0, 120);
                if ($urandom_range(0, 9) < 7)
                    w = $urandom_range(int'(cfg_now.min_width), int'(cfg_now.max_width));
                else
                    w = int'($urandom_range(0, 80)) - 20;
                r = f + w;
                if (r < 0) r = 0;
                if (r > 127) r = 127;
                level = $urandom_range(1, 1023);
                depth = $urandom_range(1, level);
                noise = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, depth / 4);
                send_line(shape, f, r, level, depth, noise, $urandom_range(0, 15) != 0,
                          ($urandom_range(0, 7) == 0) ? $urandom_range(1, 127) : 0,
                          ($urandom_range(0, 7) == 0) ? $urandom_range(1, 20) : 0,
                          1'b0, 1'b0, '0);
                rand_lines++;
            end
        end

        s_tvalid <= 1'b0;
        for (wait_cycles = 0; steer_q.size() != 0 && wait_cycles < DRAIN_LIMIT; wait_cycles++)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (steer_q.size() != 0)
            flag_error($sformatf("%0d expected items never came out", steer_q.size()));

        $display("run: %0d pixels in %0d lines, %0d register writes, %0d mismatches",
                 pixels_used, lines_sent, reg_writes, errors);
        $display("results: %0d proportional, %0d hard left, %0d hard right",
                 seen_prop, seen_left, seen_right);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
